/* design/cvr_pkg.sv */
// Shared constants for the cosine-to-reference-vector pipeline.
// No dependencies.
package cvr_pkg;

  localparam int unsigned COMP_BITS_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned COS_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REF_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Z = 2'd2;

endpackage

/* design/cosine_to_reference_vector.sv */
// Cosine of the angle between a streamed 3-D vector and a reference vector.
// Takes one word per cycle while the pipeline is not held by out_stall_i.
// Depth is set by the bit-per-stage square root and divider pipelines.
// The whole pipeline holds while a result waits on out_stall_i.
// Async active-low reset clears valid bits and the reference vector to zero.
module cosine_to_reference_vector #(
  parameter int unsigned COMP_BITS = cvr_pkg::COMP_BITS_DEF,
  parameter int unsigned FRAC_BITS = cvr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [COMP_BITS-1:0]          vec_x_i,
  input  logic [COMP_BITS-1:0]          vec_y_i,
  input  logic [COMP_BITS-1:0]          vec_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cvr_pkg::COS_W-1:0]     cosine_o,
  output logic                          zero_norm_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cvr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COMP_BITS-1:0]          cfg_data_i
);

  localparam int unsigned DW = 2 * COMP_BITS;
  localparam int unsigned XW = 4 * COMP_BITS;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned SW = (QW + 1 > cvr_pkg::COS_W) ? QW + 1 : cvr_pkg::COS_W;
  localparam logic [QW-1:0] LIM = QW'(1) << FRAC_BITS;

  logic en;
  logic [COMP_BITS-1:0] ref_x_q, ref_y_q, ref_z_q;

  logic          fr_vld, fr_dneg, fr_zero;
  logic [XW-1:0] fr_prod;
  logic [DW-1:0] fr_dmag;

  logic            sq_vld;
  logic [DW-1:0]   sq_root;
  logic [DW+1:0]   sq_sb;

  logic          dv_vld;
  logic [QW-1:0] dv_quo, quo_c;
  logic [1:0]    dv_sb;
  logic [SW-1:0] cos_s;

  logic                      out_vld_q, zero_q;
  logic [cvr_pkg::COS_W-1:0] cos_q;

  assign en          = ~(out_vld_q & out_stall_i);
  assign in_stall_o  = ~en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_x_q <= '0;
      ref_y_q <= '0;
      ref_z_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cvr_pkg::REG_REF_X: ref_x_q <= cfg_data_i;
        cvr_pkg::REG_REF_Y: ref_y_q <= cfg_data_i;
        cvr_pkg::REG_REF_Z: ref_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cvr_front #(.COMP_BITS(COMP_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .vec_x_i     (vec_x_i),
    .vec_y_i     (vec_y_i),
    .vec_z_i     (vec_z_i),
    .ref_x_i     (ref_x_q),
    .ref_y_i     (ref_y_q),
    .ref_z_i     (ref_z_q),
    .valid_o     (fr_vld),
    .norm_prod_o (fr_prod),
    .dmag_o      (fr_dmag),
    .dneg_o      (fr_dneg),
    .zero_o      (fr_zero)
  );

  cvr_isqrt #(.COMP_BITS(COMP_BITS), .SB_W(DW + 2)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .rad_i   (fr_prod),
    .sb_i    ({fr_zero, fr_dneg, fr_dmag}),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  cvr_div #(.COMP_BITS(COMP_BITS), .FRAC_BITS(FRAC_BITS), .SB_W(2)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .num_i   (sq_sb[DW-1:0]),
    .den_i   (sq_root),
    .sb_i    (sq_sb[DW+1:DW]),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .sb_o    (dv_sb)
  );

  // dv_sb = {zero, dneg}
  always_comb begin
    quo_c = (dv_quo > LIM) ? LIM : dv_quo;
    cos_s = dv_sb[0] ? (SW'(0) - SW'(quo_c)) : SW'(quo_c);
    if (dv_sb[1]) begin
      cos_s = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_q  <= cos_s[cvr_pkg::COS_W-1:0];
      zero_q <= dv_sb[1];
    end
  end

  assign out_valid_o = out_vld_q;
  assign cosine_o    = cos_q;
  assign zero_norm_o = zero_q;

endmodule

/* design/cvr_front.sv */
// Front end: magnitudes, products, dot product and norms, norm product.
// Five register stages. Uses no package items.
module cvr_front #(
  parameter int unsigned COMP_BITS = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [COMP_BITS-1:0]     vec_x_i,
  input  logic [COMP_BITS-1:0]     vec_y_i,
  input  logic [COMP_BITS-1:0]     vec_z_i,
  input  logic [COMP_BITS-1:0]     ref_x_i,
  input  logic [COMP_BITS-1:0]     ref_y_i,
  input  logic [COMP_BITS-1:0]     ref_z_i,
  output logic                     valid_o,
  output logic [4*COMP_BITS-1:0]   norm_prod_o,
  output logic [2*COMP_BITS-1:0]   dmag_o,
  output logic                     dneg_o,
  output logic                     zero_o
);

  localparam int unsigned C  = COMP_BITS;
  localparam int unsigned PW = 2 * C;
  localparam int unsigned XW = 4 * C;

  logic [4:0] vld_q;

  logic [2:0][C-1:0] va, vb;
  logic [2:0][C-1:0] am_d, bm_d, am_q, bm_q;
  logic [2:0]        an_d, bn_d, an_q, bn_q;

  logic [2:0][PW-1:0] sqa_d, sqb_d, pr_d, sqa_q, sqb_q, pr_q;
  logic [2:0]         sgn_q;

  logic [PW-1:0] na_d, nb_d, pos_d, neg_d, na_q, nb_q, pos_q, neg_q;

  logic [PW-1:0] pp11_d, pp10_d, pp01_d, pp00_d, pp11_q, pp10_q, pp01_q, pp00_q;
  logic [PW-1:0] dmag_d, dmag4_q, dmag5_q;
  logic          dneg_d, zero_d, dneg4_q, dneg5_q, zero4_q, zero5_q;
  logic [XW-1:0] prod_d, prod_q;

  assign va = {vec_z_i, vec_y_i, vec_x_i};
  assign vb = {ref_z_i, ref_y_i, ref_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      an_d[i] = va[i][C-1];
      bn_d[i] = vb[i][C-1];
      am_d[i] = an_d[i] ? (~va[i] + C'(1)) : va[i];
      bm_d[i] = bn_d[i] ? (~vb[i] + C'(1)) : vb[i];
      sqa_d[i] = PW'(am_q[i]) * PW'(am_q[i]);
      sqb_d[i] = PW'(bm_q[i]) * PW'(bm_q[i]);
      pr_d[i]  = PW'(am_q[i]) * PW'(bm_q[i]);
    end
  end

  always_comb begin
    na_d  = sqa_q[0] + sqa_q[1] + sqa_q[2];
    nb_d  = sqb_q[0] + sqb_q[1] + sqb_q[2];
    pos_d = '0;
    neg_d = '0;
    for (int i = 0; i < 3; i++) begin
      if (sgn_q[i]) begin
        neg_d = neg_d + pr_q[i];
      end else begin
        pos_d = pos_d + pr_q[i];
      end
    end
  end

  always_comb begin
    dneg_d = pos_q < neg_q;
    dmag_d = dneg_d ? (neg_q - pos_q) : (pos_q - neg_q);
    zero_d = (na_q == '0) || (nb_q == '0);
    pp11_d = PW'(na_q[PW-1:C]) * PW'(nb_q[PW-1:C]);
    pp10_d = PW'(na_q[PW-1:C]) * PW'(nb_q[C-1:0]);
    pp01_d = PW'(na_q[C-1:0])  * PW'(nb_q[PW-1:C]);
    pp00_d = PW'(na_q[C-1:0])  * PW'(nb_q[C-1:0]);
    prod_d = {pp11_q, pp00_q} + (XW'(pp10_q) << C) + (XW'(pp01_q) << C);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q    <= am_d;
      bm_q    <= bm_d;
      an_q    <= an_d;
      bn_q    <= bn_d;
      sqa_q   <= sqa_d;
      sqb_q   <= sqb_d;
      pr_q    <= pr_d;
      sgn_q   <= an_q ^ bn_q;
      na_q    <= na_d;
      nb_q    <= nb_d;
      pos_q   <= pos_d;
      neg_q   <= neg_d;
      pp11_q  <= pp11_d;
      pp10_q  <= pp10_d;
      pp01_q  <= pp01_d;
      pp00_q  <= pp00_d;
      dmag4_q <= dmag_d;
      dneg4_q <= dneg_d;
      zero4_q <= zero_d;
      prod_q  <= prod_d;
      dmag5_q <= dmag4_q;
      dneg5_q <= dneg4_q;
      zero5_q <= zero4_q;
    end
  end

  assign valid_o     = vld_q[4];
  assign norm_prod_o = prod_q;
  assign dmag_o      = dmag5_q;
  assign dneg_o      = dneg5_q;
  assign zero_o      = zero5_q;

endmodule

/* design/cvr_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Carries a sideband word alongside. Uses no package items.
module cvr_isqrt #(
  parameter int unsigned COMP_BITS = 24,
  parameter int unsigned SB_W      = 50
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [4*COMP_BITS-1:0] rad_i,
  input  logic [SB_W-1:0]        sb_i,
  output logic                   valid_o,
  output logic [2*COMP_BITS-1:0] root_o,
  output logic [SB_W-1:0]        sb_o
);

  localparam int unsigned SW = 2 * COMP_BITS;
  localparam int unsigned RW = SW + 2;
  localparam int unsigned XW = 4 * COMP_BITS;

  logic [RW-1:0]   rem_q  [SW];
  logic [SW-1:0]   root_q [SW];
  logic [XW-1:0]   rad_q  [SW];
  logic [SB_W-1:0] sb_q   [SW];
  logic [SW-1:0]   vld_q;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    localparam int unsigned B = 2 * (SW - 1 - k);
    logic [RW-1:0]   rem_p, rem_n, trial, rem_d;
    logic [SW-1:0]   root_p, root_d;
    logic [XW-1:0]   rad_p;
    logic [SB_W-1:0] sb_p;
    logic            vld_p, ge;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
      assign sb_p   = sb_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign sb_p   = sb_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    always_comb begin
      rem_n  = {rem_p[RW-3:0], rad_p[B+1:B]};
      trial  = {root_p, 2'b01};
      ge     = rem_n >= trial;
      rem_d  = ge ? (rem_n - trial) : rem_n;
      root_d = {root_p[SW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= rad_p;
        sb_q[k]   <= sb_p;
      end
    end
  end

  assign valid_o = vld_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign sb_o    = sb_q[SW-1];

endmodule

/* design/cvr_div.sv */
// Pipelined fractional divider: floor(num * 2^FRAC_BITS / den) with num <= den,
// one quotient bit per stage. Uses no package items.
module cvr_div #(
  parameter int unsigned COMP_BITS = 24,
  parameter int unsigned FRAC_BITS = 14,
  parameter int unsigned SB_W      = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [2*COMP_BITS-1:0] num_i,
  input  logic [2*COMP_BITS-1:0] den_i,
  input  logic [SB_W-1:0]        sb_i,
  output logic                   valid_o,
  output logic [FRAC_BITS:0]     quo_o,
  output logic [SB_W-1:0]        sb_o
);

  localparam int unsigned DW = 2 * COMP_BITS;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned NS = FRAC_BITS + 1;

  logic [RW-1:0]   rem_q [NS];
  logic [DW-1:0]   den_q [NS];
  logic [QW-1:0]   quo_q [NS];
  logic [SB_W-1:0] sb_q  [NS];
  logic [NS-1:0]   vld_q;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    logic [RW-1:0]   rem_n, rem_d;
    logic [DW-1:0]   den_p;
    logic [QW-1:0]   quo_p, quo_d;
    logic [SB_W-1:0] sb_p;
    logic            vld_p, ge;

    if (j == 0) begin : g_first
      assign rem_n = RW'(num_i);
      assign den_p = den_i;
      assign quo_p = '0;
      assign sb_p  = sb_i;
      assign vld_p = valid_i;
    end else begin : g_next
      assign rem_n = {rem_q[j-1][RW-2:0], 1'b0};
      assign den_p = den_q[j-1];
      assign quo_p = quo_q[j-1];
      assign sb_p  = sb_q[j-1];
      assign vld_p = vld_q[j-1];
    end

    always_comb begin
      ge    = rem_n >= RW'(den_p);
      rem_d = ge ? (rem_n - RW'(den_p)) : rem_n;
      quo_d = {quo_p[QW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_p;
        quo_q[j] <= quo_d;
        sb_q[j]  <= sb_p;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quo_o   = quo_q[NS-1];
  assign sb_o    = sb_q[NS-1];

endmodule

/* design/cvr_checker.sv */
// Port-level checks for cosine_to_reference_vector, bound to the top level.
// Depends on cvr_pkg.
module cvr_checker #(
  parameter int unsigned FRAC_BITS = cvr_pkg::FRAC_BITS_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [cvr_pkg::COS_W-1:0] cosine_o,
  input logic                      zero_norm_o
);

  localparam int LIM = 1 << FRAC_BITS;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cosine_o) && $stable(zero_norm_o))
    else $error("stalled result word changed");

  a_zero_cos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> cosine_o == '0)
    else $error("zero norm with nonzero cosine");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (FRAC_BITS > 14) ||
      (int'($signed(cosine_o)) <= LIM && int'($signed(cosine_o)) >= -LIM))
    else $error("cosine out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind cosine_to_reference_vector cvr_checker #(.FRAC_BITS(FRAC_BITS)) u_cvr_checker (.*);
